/* hdl/slpwm_pkg.sv */
// Shared types and constants for the slew-limited multichannel PWM core.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package slpwm_pkg;

	// Channel and phase geometry.
	localparam int CHANNELS = 8;
	localparam int PHASE_BITS = 10;
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int NUM_SUPPLIES = (CHANNELS / 2 < 4) ? CHANNELS / 2 : 4;

	// Field widths of the ports.
	localparam int DUTY_W = 16;
	localparam int SCALE_W = 18;
	localparam int PROD_W = DUTY_W + SCALE_W;
	localparam int PINS_W = 8;
	localparam int EN_W = 4;

	// Queue between the command front and the channel back end.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);
	localparam int Q_CW = $clog2(Q_DEPTH + 1);

	// Command modes on the item channel.
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_SET_VOLT = 2'd1;
	localparam logic [1:0] MODE_SET_CURR = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] CFG_SCALE_ONE = 3'd0;
	localparam logic [2:0] CFG_SCALE_TWO = 3'd1;
	localparam logic [2:0] CFG_SCALE_THREE = 3'd2;
	localparam logic [2:0] CFG_SCALE_FOUR = 3'd3;
	localparam logic [2:0] CFG_SCALE_CURRENT = 3'd4;
	localparam logic [2:0] CFG_SLOPE_STEP = 3'd5;
	localparam logic [2:0] CFG_SLOPE_INTERVAL = 3'd6;

	// Configuration reset values.
	localparam logic [SCALE_W-1:0] RST_SCALE_ONE = 18'd22436;
	localparam logic [SCALE_W-1:0] RST_SCALE_TWO = 18'd20874;
	localparam logic [SCALE_W-1:0] RST_SCALE_THREE = 18'd20886;
	localparam logic [SCALE_W-1:0] RST_SCALE_FOUR = 18'd20535;
	localparam logic [SCALE_W-1:0] RST_SCALE_CURRENT = 18'd66876;
	localparam logic [15:0] RST_SLOPE_STEP = 16'd12;
	localparam logic [15:0] RST_SLOPE_INTERVAL = 16'd2048;

	// Item and result payloads.
	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] supply;
		logic [15:0] amount;
	} item_t;

	typedef struct packed {
		logic [PINS_W-1:0] pwm_pins;
		logic [EN_W-1:0] supply_enables;
	} result_t;

	// Live configuration seen by the front and the back end.
	typedef struct packed {
		logic [3:0][SCALE_W-1:0] scale_v;
		logic [SCALE_W-1:0] scale_i;
		logic [15:0] slope_step;
		logic [15:0] slope_interval;
	} cfg_t;

	// Classified operation handed to the back end.
	typedef enum logic [1:0] {
		OP_TICK,
		OP_SET,
		OP_NONE
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		logic [CH_W-1:0] ch;
		logic [DUTY_W-1:0] duty;
	} op_t;

endpackage

/* hdl/slew_limited_multichannel_pwm_core.sv */
// Path: an item passes the decode and multiply stages and the queue before the result register holds its result.
// Throughput: one item per cycle; the front, the queue and the channel back end each stall
// on their own, and the result register frees its slot in the cycle it is taken.
// Reset (arst_n low): all duties, phases, the interval counter, pins and enables clear
// to zero and the configuration registers return to their default values.
// Top level: configuration registers and the front, queue and back end; uses slpwm_pkg.
module slew_limited_multichannel_pwm_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  slpwm_pkg::item_t                    item,
	output logic                                result_valid,
	input  logic                                result_ready,
	output slpwm_pkg::result_t                  result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [2:0]                          cfg_index,
	input  logic [slpwm_pkg::SCALE_W-1:0]       cfg_data
);

	slpwm_pkg::cfg_t     cfg_q;
	logic                push;
	logic                push_ready;
	slpwm_pkg::op_t      push_op;
	logic                pop_valid;
	logic                pop;
	slpwm_pkg::op_t      pop_op;

	assign cfg_ready = 1'b1;

	// Configuration registers; writes to an unknown index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_v[0] <= slpwm_pkg::RST_SCALE_ONE;
			cfg_q.scale_v[1] <= slpwm_pkg::RST_SCALE_TWO;
			cfg_q.scale_v[2] <= slpwm_pkg::RST_SCALE_THREE;
			cfg_q.scale_v[3] <= slpwm_pkg::RST_SCALE_FOUR;
			cfg_q.scale_i <= slpwm_pkg::RST_SCALE_CURRENT;
			cfg_q.slope_step <= slpwm_pkg::RST_SLOPE_STEP;
			cfg_q.slope_interval <= slpwm_pkg::RST_SLOPE_INTERVAL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				slpwm_pkg::CFG_SCALE_ONE: cfg_q.scale_v[0] <= cfg_data;
				slpwm_pkg::CFG_SCALE_TWO: cfg_q.scale_v[1] <= cfg_data;
				slpwm_pkg::CFG_SCALE_THREE: cfg_q.scale_v[2] <= cfg_data;
				slpwm_pkg::CFG_SCALE_FOUR: cfg_q.scale_v[3] <= cfg_data;
				slpwm_pkg::CFG_SCALE_CURRENT: cfg_q.scale_i <= cfg_data;
				slpwm_pkg::CFG_SLOPE_STEP: cfg_q.slope_step <= cfg_data[15:0];
				slpwm_pkg::CFG_SLOPE_INTERVAL: cfg_q.slope_interval <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Command front end.
	slpwm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push       (push),
		.push_ready (push_ready),
		.push_op    (push_op)
	);

	// Operation queue.
	slpwm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_op    (push_op),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_op     (pop_op)
	);

	// Channel back end.
	slpwm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.pop_valid    (pop_valid),
		.pop          (pop),
		.pop_op       (pop_op),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

/* hdl/slpwm_front.sv */
// Command front end: accepts items, classifies them and scales set amounts into duties.
// Depends on slpwm_pkg; feeds slpwm_queue.
module slpwm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  slpwm_pkg::cfg_t     cfg,
	input  logic                item_valid,
	output logic                item_ready,
	input  slpwm_pkg::item_t    item,
	output logic                push,
	input  logic                push_ready,
	output slpwm_pkg::op_t      push_op
);

	// Stage 1 holds the decoded command and the selected scale.
	logic                            valid_s1;
	slpwm_pkg::op_kind_t             kind_s1;
	logic [slpwm_pkg::CH_W-1:0]      ch_s1;
	logic [15:0]                     amount_s1;
	logic [slpwm_pkg::SCALE_W-1:0]   scale_s1;

	// Stage 2 holds the raw product.
	logic                            valid_s2;
	slpwm_pkg::op_kind_t             kind_s2;
	logic [slpwm_pkg::CH_W-1:0]      ch_s2;
	logic [slpwm_pkg::PROD_W-1:0]    prod_s2;

	logic                            adv_s2;
	logic                            supply_ok;
	logic                            is_set;
	logic                            is_curr;
	logic [2:0]                      sup_m1;
	logic [3:0]                      ch_full;
	slpwm_pkg::op_kind_t             kind_dec;

	// Handshake chain: each stage moves when the one after it has room.
	assign adv_s2 = !valid_s2 || push_ready;
	assign item_ready = !valid_s1 || adv_s2;
	assign push = valid_s2;

	// Classify the incoming command and pick its channel.
	always_comb begin
		is_curr = (item.mode == slpwm_pkg::MODE_SET_CURR);
		is_set = (item.mode == slpwm_pkg::MODE_SET_VOLT) || is_curr;
		supply_ok = (item.supply >= 3'd1) &&
			({29'd0, item.supply} <= 32'(slpwm_pkg::NUM_SUPPLIES));
		sup_m1 = item.supply - 3'd1;
		ch_full = {sup_m1, is_curr};
		if (item.mode == slpwm_pkg::MODE_TICK) begin
			kind_dec = slpwm_pkg::OP_TICK;
		end else if (is_set && supply_ok) begin
			kind_dec = slpwm_pkg::OP_SET;
		end else begin
			kind_dec = slpwm_pkg::OP_NONE;
		end
	end

	// Saturate the scaled product to a 16-bit duty on its way into the queue.
	always_comb begin
		push_op.kind = kind_s2;
		push_op.ch = ch_s2;
		if (|prod_s2[slpwm_pkg::PROD_W-1:32]) begin
			push_op.duty = '1;
		end else begin
			push_op.duty = prod_s2[31:16];
		end
	end

	// Stage registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			kind_s1 <= kind_dec;
			ch_s1 <= ch_full[slpwm_pkg::CH_W-1:0];
			amount_s1 <= item.amount;
			scale_s1 <= is_curr ? cfg.scale_i : cfg.scale_v[sup_m1[1:0]];
		end
		if (adv_s2 && valid_s1) begin
			kind_s2 <= kind_s1;
			ch_s2 <= ch_s1;
			prod_s2 <= slpwm_pkg::PROD_W'(amount_s1) * slpwm_pkg::PROD_W'(scale_s1);
		end
	end

	// A stalled front end always has a command waiting in stage 1.
	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> valid_s1)
		else $error("front end stalls with stage 1 empty");

endmodule

/* hdl/slpwm_queue.sv */
// Short in-order queue of classified operations between front and back end.
// Depends on slpwm_pkg for the operation type and depth.
module slpwm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                push_ready,
	input  slpwm_pkg::op_t      push_op,
	output logic                pop_valid,
	input  logic                pop,
	output slpwm_pkg::op_t      pop_op
);

	slpwm_pkg::op_t                  entry_q [slpwm_pkg::Q_DEPTH];
	logic [slpwm_pkg::Q_AW-1:0]      wr_ptr_q;
	logic [slpwm_pkg::Q_AW-1:0]      rd_ptr_q;
	logic [slpwm_pkg::Q_CW-1:0]      count_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = (count_q != slpwm_pkg::Q_CW'(slpwm_pkg::Q_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_op = entry_q[rd_ptr_q];
	assign do_push = push && push_ready;
	assign do_pop = pop && pop_valid;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	// A lone transfer into the queue raises the fill count by exactly one.
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a push");

endmodule

/* hdl/slpwm_back.sv */
// Channel back end: phase counters, slope limiter and pin compare for all channels.
// Depends on slpwm_pkg; takes operations from slpwm_queue and drives the result register.
module slpwm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  slpwm_pkg::cfg_t     cfg,
	input  logic                pop_valid,
	output logic                pop,
	input  slpwm_pkg::op_t      pop_op,
	output logic                result_valid,
	input  logic                result_ready,
	output slpwm_pkg::result_t  result
);

	localparam int N = slpwm_pkg::CHANNELS;
	localparam int DW = slpwm_pkg::DUTY_W;
	localparam int PB = slpwm_pkg::PHASE_BITS;

	logic [N-1:0][PB-1:0]            phase_q;
	logic [N-1:0][DW-1:0]            target_q;
	logic [N-1:0][DW-1:0]            applied_q;
	logic [15:0]                     interval_q;
	logic [slpwm_pkg::EN_W-1:0]      enables_q;
	logic [slpwm_pkg::PINS_W-1:0]    pins_q;
	logic                            result_valid_q;
	slpwm_pkg::result_t              result_q;

	logic [N-1:0][PB-1:0]            phase_n;
	logic [N-1:0][DW-1:0]            target_n;
	logic [N-1:0][DW-1:0]            applied_n;
	logic [N-1:0][DW-1:0]            slope_duty;
	logic [15:0]                     interval_n;
	logic [slpwm_pkg::EN_W-1:0]      enables_n;
	logic [slpwm_pkg::EN_W-1:0]      slope_en;
	logic [slpwm_pkg::PINS_W-1:0]    pins_n;
	logic                            do_slope;

	// An operation is taken whenever the result register is free or draining.
	assign pop = pop_valid && (!result_valid_q || result_ready);
	assign result_valid = result_valid_q;
	assign result = result_q;

	// Slope limiter: voltage channels step toward target, current channels copy it.
	always_comb begin
		logic [DW-1:0] a;
		logic [DW-1:0] t;
		for (int i = 0; i < N; i++) begin
			a = applied_q[i];
			t = target_q[i];
			if ((i % 2) == 0) begin
				if (a > t) begin
					slope_duty[i] = ((a - t) > cfg.slope_step) ? a - cfg.slope_step : t;
				end else if (a < t) begin
					slope_duty[i] = ((t - a) > cfg.slope_step) ? a + cfg.slope_step : t;
				end else begin
					slope_duty[i] = a;
				end
			end else begin
				slope_duty[i] = t;
			end
		end
		slope_en = '0;
		for (int n = 0; n < slpwm_pkg::NUM_SUPPLIES; n++) begin
			slope_en[n] = (slope_duty[2 * n] != '0);
		end
	end

	// Next state for the operation at the head of the queue.
	always_comb begin
		do_slope = (interval_q >= cfg.slope_interval);
		phase_n = phase_q;
		target_n = target_q;
		applied_n = applied_q;
		interval_n = interval_q;
		enables_n = enables_q;
		pins_n = pins_q;
		unique case (pop_op.kind)
			slpwm_pkg::OP_TICK: begin
				if (do_slope) begin
					applied_n = slope_duty;
					enables_n = slope_en;
					interval_n = '0;
				end else begin
					interval_n = interval_q + 16'd1;
				end
				pins_n = '0;
				for (int i = 0; i < N; i++) begin
					phase_n[i] = phase_q[i] + 1'b1;
					if ((N - 1 - i) < slpwm_pkg::PINS_W) begin
						pins_n[N - 1 - i] = (DW'(phase_n[i]) < applied_n[i]);
					end
				end
			end
			slpwm_pkg::OP_SET: begin
				target_n[pop_op.ch] = pop_op.duty;
			end
			slpwm_pkg::OP_NONE: begin
			end
			default: begin
			end
		endcase
	end

	// Channel state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			target_q <= '0;
			applied_q <= '0;
			interval_q <= '0;
			enables_q <= '0;
			pins_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_n;
				target_q <= target_n;
				applied_q <= applied_n;
				interval_q <= interval_n;
				enables_q <= enables_n;
				pins_q <= pins_n;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q.pwm_pins <= pins_n;
			result_q.supply_enables <= enables_n;
		end
	end

	// The first supply's enable always mirrors its applied voltage duty.
	a_enable_tracks_duty: assert property (@(posedge clk) disable iff (!arst_n)
		enables_q[0] == (applied_q[0] != '0))
		else $error("supply enable out of step with applied duty");

	// Set commands and ignored items never move the pins.
	a_set_keeps_pins: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (pop_op.kind != slpwm_pkg::OP_TICK)) |=> $stable(pins_q))
		else $error("pins changed on a non-tick operation");

endmodule
